// File: rtl/cmte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix transform engine package
// Shared sizes, command and status codes, and the control and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cmte_pkg;

   localparam int DIM    = 16;
   localparam int IDX_W  = $clog2(DIM);
   localparam int CNT_W  = $clog2(DIM + 1);
   localparam int CELLS  = DIM * DIM;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CMD_W  = 4;
   localparam int DATA_W = 8;
   localparam int STAT_W = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_SIZE      = 4'd0,
      CMD_WRITE     = 4'd1,
      CMD_READ      = 4'd2,
      CMD_SWAP_CELL = 4'd3,
      CMD_SWAP_ROW  = 4'd4,
      CMD_SWAP_COL  = 4'd5,
      CMD_REV_ROW   = 4'd6,
      CMD_REV_COL   = 4'd7,
      CMD_MIR_ROWS  = 4'd8,
      CMD_MIR_COLS  = 4'd9,
      CMD_ROTATE    = 4'd10,
      CMD_TRANSPOSE = 4'd11
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE       = 2'd0,
      ST_RANGE      = 2'd1,
      ST_NOT_SQUARE = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic init_loop;
      logic next_pass;
      logic step_outer;
      logic step_inner;
      logic rd_a;
      logic rd_b;
      logic wr_a;
      logic wr_b;
      logic cp_rd;
      logic cp_wr;
      logic swap_dims;
   } ctl_type;

   typedef struct packed {
      logic err;
      logic is_loop;
      logic is_rotate;
      logic outer_done;
      logic inner_done;
      logic pass1;
   } stat_type;

   function automatic addr_type cell_addr(input idx_type r, input idx_type c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c));
   endfunction

endpackage
`default_nettype wire

// File: rtl/cmte_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix transform controller
// Sequences decode, cell swap loops, rotate copy passes and the response.
// ----------------------------------------------------------------------------
module cmte_ctrl
   import cmte_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output ctl_type       ctl,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_LOOP   = 10'b0000000100,
      S_RD_A   = 10'b0000001000,
      S_RD_B   = 10'b0000010000,
      S_WR_A   = 10'b0000100000,
      S_WR_B   = 10'b0001000000,
      S_CP_RD  = 10'b0010000000,
      S_CP_WR  = 10'b0100000000,
      S_RESP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.decode = 1'b1;
            if (!stat.err && stat.is_loop) begin
               ctl.init_loop = 1'b1;
               state_in      = S_LOOP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_LOOP: begin
            if (stat.outer_done) begin
               if (stat.is_rotate && !stat.pass1) begin
                  ctl.next_pass = 1'b1;
               end else begin
                  ctl.swap_dims = stat.is_rotate;
                  state_in      = S_RESP;
               end
            end else if (stat.inner_done) begin
               ctl.step_outer = 1'b1;
            end else begin
               state_in = stat.is_rotate ? S_CP_RD : S_RD_A;
            end
         end
         S_RD_A: begin
            ctl.rd_a = 1'b1;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            ctl.rd_b = 1'b1;
            state_in = S_WR_A;
         end
         S_WR_A: begin
            ctl.wr_a = 1'b1;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            ctl.wr_b       = 1'b1;
            ctl.step_inner = 1'b1;
            state_in       = S_LOOP;
         end
         S_CP_RD: begin
            ctl.cp_rd = 1'b1;
            state_in  = S_CP_WR;
         end
         S_CP_WR: begin
            ctl.cp_wr      = 1'b1;
            ctl.step_inner = 1'b1;
            state_in       = S_LOOP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule
`default_nettype wire

// File: rtl/cmte_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix transform datapath
// Holds the cell and scratch memories, the size registers, the loop
// counters and the address generation for every command.
// ----------------------------------------------------------------------------
module cmte_datapath
   import cmte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           ctl,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [IDX_W-1:0]  req_row_a,
   input  wire logic [IDX_W-1:0]  req_col_a,
   input  wire logic [IDX_W-1:0]  req_row_b,
   input  wire logic [IDX_W-1:0]  req_col_b,
   input  wire logic [CNT_W-1:0]  req_new_rows,
   input  wire logic [CNT_W-1:0]  req_new_cols,
   input  wire logic [DATA_W-1:0] req_cell_value,
   output stat_type               stat,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [DATA_W-1:0]      rsp_read_value,
   output logic [CNT_W-1:0]       rsp_rows_now,
   output logic [CNT_W-1:0]       rsp_cols_now
);

   data_type   cell_mem [CELLS];
   data_type   scratch_mem [CELLS];

   cmd_type    cmd_ff;
   idx_type    ra_ff, ca_ff, rb_ff, cb_ff;
   cnt_type    nr_ff, nc_ff;
   data_type   val_ff;
   status_type status_ff, status_now;
   cnt_type    rows_ff, rows_in, cols_ff, cols_in;
   cnt_type    o_ff, o_in, i_ff, i_in;
   logic       pass_ff, pass_in;
   data_type   cell_rd_ff, scratch_rd_ff, da_ff;

   cnt_type    outer_lim, inner_lim;
   idx_type    oi, ii, rm_i, cm_i;
   addr_type   addr_a, addr_b, cell_raddr, cell_waddr;
   data_type   cell_wdata;
   logic       cell_we, scratch_we;
   logic       ra_ok, ca_ok, rb_ok, cb_ok;

   assign ra_ok = cnt_type'(ra_ff) < rows_ff;
   assign rb_ok = cnt_type'(rb_ff) < rows_ff;
   assign ca_ok = cnt_type'(ca_ff) < cols_ff;
   assign cb_ok = cnt_type'(cb_ff) < cols_ff;

   always_comb begin
      status_now = ST_DONE;
      case (cmd_ff)
         CMD_SIZE: begin
            if (nr_ff > cnt_type'(DIM) || nc_ff > cnt_type'(DIM)) status_now = ST_RANGE;
         end
         CMD_WRITE, CMD_READ: begin
            if (!(ra_ok && ca_ok)) status_now = ST_RANGE;
         end
         CMD_SWAP_CELL: begin
            if (!(ra_ok && ca_ok && rb_ok && cb_ok)) status_now = ST_RANGE;
         end
         CMD_SWAP_ROW: begin
            if (!(ra_ok && rb_ok)) status_now = ST_RANGE;
         end
         CMD_SWAP_COL: begin
            if (!(ca_ok && cb_ok)) status_now = ST_RANGE;
         end
         CMD_REV_ROW: begin
            if (!ra_ok) status_now = ST_RANGE;
         end
         CMD_REV_COL: begin
            if (!ca_ok) status_now = ST_RANGE;
         end
         CMD_MIR_ROWS, CMD_MIR_COLS, CMD_ROTATE: begin
            status_now = ST_DONE;
         end
         CMD_TRANSPOSE: begin
            if (rows_ff != cols_ff) status_now = ST_NOT_SQUARE;
         end
         default: begin
            status_now = ST_RANGE;
         end
      endcase
   end

   assign oi   = o_ff[IDX_W-1:0];
   assign ii   = i_ff[IDX_W-1:0];
   assign rm_i = idx_type'(rows_ff - cnt_type'(1) - i_ff);
   assign cm_i = idx_type'(cols_ff - cnt_type'(1) - i_ff);

   always_comb begin
      outer_lim = cnt_type'(1);
      inner_lim = cnt_type'(1);
      addr_a    = cell_addr(ra_ff, ca_ff);
      addr_b    = cell_addr(rb_ff, cb_ff);
      case (cmd_ff)
         CMD_SWAP_ROW: begin
            inner_lim = cols_ff;
            addr_a    = cell_addr(ra_ff, ii);
            addr_b    = cell_addr(rb_ff, ii);
         end
         CMD_SWAP_COL: begin
            inner_lim = rows_ff;
            addr_a    = cell_addr(ii, ca_ff);
            addr_b    = cell_addr(ii, cb_ff);
         end
         CMD_REV_ROW: begin
            inner_lim = cols_ff >> 1;
            addr_a    = cell_addr(ra_ff, ii);
            addr_b    = cell_addr(ra_ff, cm_i);
         end
         CMD_REV_COL: begin
            inner_lim = rows_ff >> 1;
            addr_a    = cell_addr(ii, ca_ff);
            addr_b    = cell_addr(rm_i, ca_ff);
         end
         CMD_MIR_ROWS: begin
            outer_lim = rows_ff;
            inner_lim = cols_ff >> 1;
            addr_a    = cell_addr(oi, ii);
            addr_b    = cell_addr(oi, cm_i);
         end
         CMD_MIR_COLS: begin
            outer_lim = cols_ff;
            inner_lim = rows_ff >> 1;
            addr_a    = cell_addr(ii, oi);
            addr_b    = cell_addr(rm_i, oi);
         end
         CMD_ROTATE: begin
            outer_lim = cols_ff;
            inner_lim = rows_ff;
            addr_a    = cell_addr(rm_i, oi);
            addr_b    = cell_addr(oi, ii);
         end
         CMD_TRANSPOSE: begin
            outer_lim = rows_ff;
            inner_lim = cols_ff;
            addr_a    = cell_addr(oi, ii);
            addr_b    = cell_addr(ii, oi);
         end
         default: begin
            outer_lim = cnt_type'(1);
         end
      endcase
   end

   assign stat.err        = (status_now != ST_DONE);
   assign stat.is_loop    = (cmd_ff >= CMD_SWAP_CELL) && (cmd_ff <= CMD_TRANSPOSE);
   assign stat.is_rotate  = (cmd_ff == CMD_ROTATE);
   assign stat.outer_done = (o_ff >= outer_lim);
   assign stat.inner_done = (i_ff >= inner_lim);
   assign stat.pass1      = pass_ff;

   always_comb begin
      o_in    = o_ff;
      i_in    = i_ff;
      pass_in = pass_ff;
      if (ctl.init_loop || ctl.next_pass) begin
         o_in    = '0;
         i_in    = (cmd_ff == CMD_TRANSPOSE) ? cnt_type'(1) : '0;
         pass_in = ctl.next_pass;
      end else if (ctl.step_outer) begin
         o_in = o_ff + cnt_type'(1);
         i_in = (cmd_ff == CMD_TRANSPOSE) ? o_ff + cnt_type'(2) : '0;
      end else if (ctl.step_inner) begin
         i_in = i_ff + cnt_type'(1);
      end
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (ctl.decode && cmd_ff == CMD_SIZE && status_now == ST_DONE) begin
         rows_in = nr_ff;
         cols_in = nc_ff;
      end else if (ctl.swap_dims) begin
         rows_in = cols_ff;
         cols_in = rows_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         cols_ff <= '0;
         o_ff    <= '0;
         i_ff    <= '0;
         pass_ff <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         o_ff    <= o_in;
         i_ff    <= i_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= cmd_type'(req_cmd);
         ra_ff  <= req_row_a;
         ca_ff  <= req_col_a;
         rb_ff  <= req_row_b;
         cb_ff  <= req_col_b;
         nr_ff  <= req_new_rows;
         nc_ff  <= req_new_cols;
         val_ff <= req_cell_value;
      end
      if (ctl.decode) begin
         status_ff <= status_now;
      end
      if (ctl.rd_b) begin
         da_ff <= cell_rd_ff;
      end
   end

   always_comb begin
      cell_raddr = addr_a;
      if (ctl.decode) begin
         cell_raddr = cell_addr(ra_ff, ca_ff);
      end else if (ctl.rd_b) begin
         cell_raddr = addr_b;
      end else if (ctl.rd_a || ctl.cp_rd) begin
         cell_raddr = addr_a;
      end
   end

   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = addr_b;
      cell_wdata = da_ff;
      scratch_we = ctl.cp_wr && !pass_ff;
      if (ctl.decode && cmd_ff == CMD_WRITE && status_now == ST_DONE) begin
         cell_we    = 1'b1;
         cell_waddr = cell_addr(ra_ff, ca_ff);
         cell_wdata = val_ff;
      end else if (ctl.wr_a) begin
         cell_we    = 1'b1;
         cell_waddr = addr_a;
         cell_wdata = cell_rd_ff;
      end else if (ctl.wr_b) begin
         cell_we = 1'b1;
      end else if (ctl.cp_wr && pass_ff) begin
         cell_we    = 1'b1;
         cell_wdata = scratch_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (scratch_we) begin
         scratch_mem[addr_b] <= cell_rd_ff;
      end
      scratch_rd_ff <= scratch_mem[addr_b];
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = (cmd_ff == CMD_READ && status_ff == ST_DONE) ? cell_rd_ff : '0;
   assign rsp_rows_now   = rows_ff;
   assign rsp_cols_now   = cols_ff;

endmodule
`default_nettype wire

// File: rtl/char_matrix_transform_engine.sv
`default_nettype none
// Size, write, read and rejected commands go from start through decode to the strobe.
// Swap, reverse, mirror and transpose loop over cell pairs (read A, read B, write A,
// write B), stepping an outer pass (rows or columns for a mirror or transpose, else one).
// Rotate copies every cell to scratch and back in two passes through one memory read port.
// One item at a time: busy is high from the accepting edge until the strobe cycle ends.
// The receiver cannot stall the one-cycle strobe; reset zeroes the counts, not the cells.
// ----------------------------------------------------------------------------
// Matrix transform engine
// Top level joining the command controller and the matrix datapath.
// ----------------------------------------------------------------------------
module char_matrix_transform_engine
   import cmte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [IDX_W-1:0]  req_row_a,
   input  wire logic [IDX_W-1:0]  req_col_a,
   input  wire logic [IDX_W-1:0]  req_row_b,
   input  wire logic [IDX_W-1:0]  req_col_b,
   input  wire logic [CNT_W-1:0]  req_new_rows,
   input  wire logic [CNT_W-1:0]  req_new_cols,
   input  wire logic [DATA_W-1:0] req_cell_value,
   output logic                   rsp_strobe,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [DATA_W-1:0]      rsp_read_value,
   output logic [CNT_W-1:0]       rsp_rows_now,
   output logic [CNT_W-1:0]       rsp_cols_now
);

   ctl_type  ctl;
   stat_type stat;

   cmte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cmte_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_cmd        (req_cmd),
      .req_row_a      (req_row_a),
      .req_col_a      (req_col_a),
      .req_row_b      (req_row_b),
      .req_col_b      (req_col_b),
      .req_new_rows   (req_new_rows),
      .req_new_cols   (req_new_cols),
      .req_cell_value (req_cell_value),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_rows_now   (rsp_rows_now),
      .rsp_cols_now   (rsp_cols_now)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted item did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe longer than one cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_counts_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_rows_now <= CNT_W'(DIM) && rsp_cols_now <= CNT_W'(DIM))
      else $error("matrix count above limit");

endmodule
`default_nettype wire

// File: tb/sv/char_matrix_transform_engine_test.sv
// ----------------------------------------------------------------------------
// Matrix transform engine testbench
// A table of directed commands, then about 700 random commands, drives the
// engine. A behavioral model of the byte matrix predicts each result the
// table does not give; the result stream is checked in order. Written cells
// are tracked so that no read ever targets an unwritten cell.
// ----------------------------------------------------------------------------
module char_matrix_transform_engine_test;
   import cmte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 8000000;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  ra, ca, rb, cb;
      logic [CNT_W-1:0]  nr, nc;
      logic [DATA_W-1:0] val;
   } item_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] rd;
      logic [CNT_W-1:0]  rows;
      logic [CNT_W-1:0]  cols;
   } result_type;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0]  req_cmd = '0;
   logic [IDX_W-1:0]  req_row_a = '0, req_col_a = '0, req_row_b = '0, req_col_b = '0;
   logic [CNT_W-1:0]  req_new_rows = '0, req_new_cols = '0;
   logic [DATA_W-1:0] req_cell_value = '0;
   logic rsp_strobe;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]  rsp_rows_now, rsp_cols_now;

   logic [DATA_W-1:0] grid [CELLS];
   bit                grid_written [CELLS];
   int unsigned       grid_rows, grid_cols;
   result_type        pending_results [$];
   result_type        oldest;
   int                fail_count = 0;
   int                cycle_count = 0;
   int                idle_pct = 23;

   char_matrix_transform_engine u_top (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_row_a, .req_col_a, .req_row_b, .req_col_b,
      .req_new_rows, .req_new_cols, .req_cell_value,
      .rsp_strobe, .rsp_status, .rsp_read_value, .rsp_rows_now, .rsp_cols_now
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, rsp_status);
            fail_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status) begin
               $display("%0t: status expected %0d actual %0d", $time, oldest.status, rsp_status);
               fail_count++;
            end
            if (rsp_read_value !== oldest.rd) begin
               $display("%0t: read_value expected %0d actual %0d", $time, oldest.rd,
                        rsp_read_value);
               fail_count++;
            end
            if (rsp_rows_now !== oldest.rows) begin
               $display("%0t: rows_now expected %0d actual %0d", $time, oldest.rows,
                        rsp_rows_now);
               fail_count++;
            end
            if (rsp_cols_now !== oldest.cols) begin
               $display("%0t: cols_now expected %0d actual %0d", $time, oldest.cols,
                        rsp_cols_now);
               fail_count++;
            end
         end
      end
   end

   function automatic int unsigned pos(int unsigned r, int unsigned c);
      return (r * DIM + c) % CELLS;
   endfunction

   function automatic void swap_pos(int unsigned a, int unsigned b);
      logic [DATA_W-1:0] t;
      bit w;
      t = grid[a];
      grid[a] = grid[b];
      grid[b] = t;
      w = grid_written[a];
      grid_written[a] = grid_written[b];
      grid_written[b] = w;
   endfunction

   function automatic void flip_row(int unsigned r);
      for (int unsigned x = 0; x < grid_cols / 2; x++)
         swap_pos(pos(r, x), pos(r, grid_cols - 1 - x));
   endfunction

   function automatic void flip_col(int unsigned c);
      for (int unsigned x = 0; x < grid_rows / 2; x++)
         swap_pos(pos(x, c), pos(grid_rows - 1 - x, c));
   endfunction

   function automatic result_type apply_matrix_cmd(item_type it);
      result_type r;
      int unsigned nr, nc;
      bit ra_ok, rb_ok, ca_ok, cb_ok;
      logic [DATA_W-1:0] tmp [CELLS];
      bit tmp_w [CELLS];
      nr = grid_rows;
      nc = grid_cols;
      ra_ok = it.ra < nr;
      rb_ok = it.rb < nr;
      ca_ok = it.ca < nc;
      cb_ok = it.cb < nc;
      r.status = ST_DONE;
      r.rd = '0;
      case (it.cmd)
         CMD_SIZE: begin
            if (it.nr > DIM || it.nc > DIM) r.status = ST_RANGE;
            else begin
               grid_rows = 32'(it.nr);
               grid_cols = 32'(it.nc);
            end
         end
         CMD_WRITE: begin
            if (ra_ok && ca_ok) begin
               grid[pos(it.ra, it.ca)] = it.val;
               grid_written[pos(it.ra, it.ca)] = 1'b1;
            end else r.status = ST_RANGE;
         end
         CMD_READ: begin
            if (ra_ok && ca_ok) r.rd = grid[pos(it.ra, it.ca)];
            else r.status = ST_RANGE;
         end
         CMD_SWAP_CELL: begin
            if (ra_ok && ca_ok && rb_ok && cb_ok) swap_pos(pos(it.ra, it.ca), pos(it.rb, it.cb));
            else r.status = ST_RANGE;
         end
         CMD_SWAP_ROW: begin
            if (ra_ok && rb_ok) begin
               for (int unsigned x = 0; x < nc; x++) swap_pos(pos(it.ra, x), pos(it.rb, x));
            end else r.status = ST_RANGE;
         end
         CMD_SWAP_COL: begin
            if (ca_ok && cb_ok) begin
               for (int unsigned x = 0; x < nr; x++) swap_pos(pos(x, it.ca), pos(x, it.cb));
            end else r.status = ST_RANGE;
         end
         CMD_REV_ROW: begin
            if (ra_ok) flip_row(it.ra);
            else r.status = ST_RANGE;
         end
         CMD_REV_COL: begin
            if (ca_ok) flip_col(it.ca);
            else r.status = ST_RANGE;
         end
         CMD_MIR_ROWS: begin
            for (int unsigned x = 0; x < nr; x++) flip_row(x);
         end
         CMD_MIR_COLS: begin
            for (int unsigned x = 0; x < nc; x++) flip_col(x);
         end
         CMD_ROTATE: begin
            for (int unsigned x = 0; x < nc; x++)
               for (int unsigned y = 0; y < nr; y++) begin
                  tmp[pos(x, y)] = grid[pos(nr - 1 - y, x)];
                  tmp_w[pos(x, y)] = grid_written[pos(nr - 1 - y, x)];
               end
            for (int unsigned x = 0; x < nc; x++)
               for (int unsigned y = 0; y < nr; y++) begin
                  grid[pos(x, y)] = tmp[pos(x, y)];
                  grid_written[pos(x, y)] = tmp_w[pos(x, y)];
               end
            grid_rows = nc;
            grid_cols = nr;
         end
         CMD_TRANSPOSE: begin
            if (nr != nc) r.status = ST_NOT_SQUARE;
            else begin
               for (int unsigned x = 0; x < nr; x++)
                  for (int unsigned y = x + 1; y < nc; y++) swap_pos(pos(x, y), pos(y, x));
            end
         end
         default: r.status = ST_RANGE;
      endcase
      r.rows = CNT_W'(grid_rows);
      r.cols = CNT_W'(grid_cols);
      return r;
   endfunction

   function automatic item_type mk(logic [CMD_W-1:0] cmd, int ra, int ca, int rb, int cb,
                                   int nr, int nc, int val);
      item_type it;
      it.cmd = cmd;
      it.ra = IDX_W'(ra);
      it.ca = IDX_W'(ca);
      it.rb = IDX_W'(rb);
      it.cb = IDX_W'(cb);
      it.nr = CNT_W'(nr);
      it.nc = CNT_W'(nc);
      it.val = DATA_W'(val);
      return it;
   endfunction

   function automatic row_type typed_row(item_type it, int st, int rd, int rows, int cols);
      row_type row;
      row.it = it;
      row.typed = 1'b1;
      row.res.status = STAT_W'(st);
      row.res.rd = DATA_W'(rd);
      row.res.rows = CNT_W'(rows);
      row.res.cols = CNT_W'(cols);
      return row;
   endfunction

   function automatic row_type model_row(item_type it);
      row_type row;
      row.it = it;
      row.typed = 1'b0;
      row.res = '{default: '0};
      return row;
   endfunction

   function automatic int unsigned pick_index(int unsigned cnt);
      if (cnt > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, cnt - 1);
      return $urandom_range(0, DIM - 1);
   endfunction

   function automatic item_type random_item();
      item_type it;
      int unsigned sel, tries;
      it.ra = IDX_W'(pick_index(grid_rows));
      it.ca = IDX_W'(pick_index(grid_cols));
      it.rb = IDX_W'(pick_index(grid_rows));
      it.cb = IDX_W'(pick_index(grid_cols));
      it.val = DATA_W'($urandom_range(0, 255));
      it.nr = CNT_W'($urandom_range(0, 6));
      it.nc = CNT_W'($urandom_range(0, 6));
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         it.cmd = CMD_SIZE;
         case ($urandom_range(0, 5))
            0: it.nr = CNT_W'($urandom_range(0, 31));
            1: it.nc = CNT_W'($urandom_range(0, 31));
            2: begin
               it.nr = CNT_W'(DIM);
               it.nc = CNT_W'($urandom_range(1, DIM));
            end
            3: it.nc = it.nr;
            default: ;
         endcase
      end else if (sel < 35) it.cmd = CMD_WRITE;
      else if (sel < 60) begin
         it.cmd = CMD_READ;
         tries = 0;
         while (it.ra < grid_rows && it.ca < grid_cols && !grid_written[pos(it.ra, it.ca)]
                && tries < 20) begin
            it.ra = IDX_W'(pick_index(grid_rows));
            it.ca = IDX_W'(pick_index(grid_cols));
            tries++;
         end
         if (it.ra < grid_rows && it.ca < grid_cols && !grid_written[pos(it.ra, it.ca)])
            it.cmd = CMD_WRITE;
      end else if (sel < 97) it.cmd = CMD_W'($urandom_range(CMD_SWAP_CELL, CMD_TRANSPOSE));
      else it.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      return it;
   endfunction

   task automatic send_item(item_type it);
      req_cmd <= it.cmd;
      req_row_a <= it.ra;
      req_col_a <= it.ca;
      req_row_b <= it.rb;
      req_col_b <= it.cb;
      req_new_rows <= it.nr;
      req_new_cols <= it.nc;
      req_cell_value <= it.val;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_gap();
      int unsigned n;
      if ($urandom_range(0, 99) < idle_pct) begin
         n = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   row_type    directed [$];
   result_type predicted;

   initial begin
      for (int i = 0; i < CELLS; i++) grid_written[i] = 1'b0;
      grid_rows = 0;
      grid_cols = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(typed_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0), ST_RANGE, 0, 0, 0));
      directed.push_back(typed_row(mk(CMD_ROTATE, 0, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 0, 0));
      directed.push_back(typed_row(mk(CMD_SIZE, 0, 0, 0, 0, 17, 0, 0), ST_RANGE, 0, 0, 0));
      directed.push_back(typed_row(mk(CMD_SIZE, 0, 0, 0, 0, 31, 31, 0), ST_RANGE, 0, 0, 0));
      directed.push_back(typed_row(mk(CMD_SIZE, 0, 0, 0, 0, 16, 16, 0), ST_DONE, 0, 16, 16));
      directed.push_back(typed_row(mk(CMD_WRITE, 15, 15, 0, 0, 0, 0, 255), ST_DONE, 0, 16, 16));
      directed.push_back(typed_row(mk(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 16, 16));
      directed.push_back(typed_row(mk(CMD_READ, 15, 15, 0, 0, 0, 0, 0), ST_DONE, 255, 16, 16));
      directed.push_back(typed_row(mk(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0, 0), ST_RANGE, 0, 16, 16));
      directed.push_back(typed_row(mk(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0, 0), ST_RANGE, 0, 16, 16));
      directed.push_back(model_row(mk(CMD_TRANSPOSE, 0, 0, 0, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_SWAP_CELL, 15, 15, 0, 0, 0, 0, 0)));
      directed.push_back(typed_row(mk(CMD_SIZE, 0, 0, 0, 0, 3, 4, 0), ST_DONE, 0, 3, 4));
      directed.push_back(typed_row(mk(CMD_TRANSPOSE, 0, 0, 0, 0, 0, 0, 0),
                                   ST_NOT_SQUARE, 0, 3, 4));
      directed.push_back(typed_row(mk(CMD_WRITE, 3, 0, 0, 0, 0, 0, 9), ST_RANGE, 0, 3, 4));
      directed.push_back(typed_row(mk(CMD_SWAP_ROW, 0, 0, 3, 0, 0, 0, 0), ST_RANGE, 0, 3, 4));
      directed.push_back(typed_row(mk(CMD_SWAP_COL, 0, 4, 0, 0, 0, 0, 0), ST_RANGE, 0, 3, 4));
      directed.push_back(model_row(mk(CMD_WRITE, 2, 3, 0, 0, 0, 0, 170)));
      directed.push_back(model_row(mk(CMD_SWAP_ROW, 2, 0, 1, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_SWAP_COL, 0, 3, 0, 1, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_REV_ROW, 1, 0, 0, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_REV_COL, 0, 2, 0, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_MIR_ROWS, 0, 0, 0, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_MIR_COLS, 0, 0, 0, 0, 0, 0, 0)));
      directed.push_back(model_row(mk(CMD_ROTATE, 0, 0, 0, 0, 0, 0, 0)));

      foreach (directed[i]) begin
         send_item(directed[i].it);
         predicted = apply_matrix_cmd(directed[i].it);
         pending_results.push_back(directed[i].typed ? directed[i].res : predicted);
         sender_gap();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         item_type it;
         if (i == RANDOM_ITEMS / 3) idle_pct = 57;
         if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
         it = random_item();
         send_item(it);
         pending_results.push_back(apply_matrix_cmd(it));
         sender_gap();
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/cmte_pkg.sv
rtl/cmte_ctrl.sv
rtl/cmte_datapath.sv
rtl/char_matrix_transform_engine.sv
tb/sv/char_matrix_transform_engine_test.sv
